FILE: rtl/jmhp_pkg.sv
// ----------------------------------------------------------------------------
// JPIP message header parser package
// Shared types, codes and constants for the header parser and its checker.
// ----------------------------------------------------------------------------
package jmhp_pkg;

  localparam int MAX_VBAS_BYTES_DEF = 9;

  localparam int ID_W   = 63;
  localparam int CLS_W  = 4;
  localparam int VAL_W  = 31;
  localparam int HLEN_W = 6;

  localparam logic [HLEN_W-1:0] HDR_LEN_MAX = 6'd63;
  localparam logic [ID_W-1:0]   CLASS_MAX   = 63'd8;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_BODY      = 3'd1,
    KIND_BAD_IND   = 3'd2,
    KIND_VBAS_LONG = 3'd3,
    KIND_BAD_CLASS = 3'd4,
    KIND_RANGE     = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_BINID   = 4'd0,
    PH_BINEXT  = 4'd1,
    PH_CLASS   = 4'd2,
    PH_CSN     = 4'd3,
    PH_OFFSET  = 4'd4,
    PH_LENGTH  = 4'd5,
    PH_AUX     = 4'd6,
    PH_BODY    = 4'd7,
    PH_EORCODE = 4'd8,
    PH_EORLEN  = 4'd9
  } phase_t;

  typedef struct packed {
    kind_t             item_kind;
    logic              is_eor;
    logic [7:0]        data_byte;
    logic [ID_W-1:0]   in_class_id;
    logic              complete_bin;
    logic [CLS_W-1:0]  class_id;
    logic [VAL_W-1:0]  codestream_id;
    logic [VAL_W-1:0]  msg_offset;
    logic [VAL_W-1:0]  msg_length;
    logic [VAL_W-1:0]  aux_value;
    logic [HLEN_W-1:0] header_length;
    logic              last_of_message;
  } res_t;

endpackage

FILE: rtl/jmhp_if.sv
// ----------------------------------------------------------------------------
// JPIP message header parser channels
// Valid/ready stream interfaces for input bytes and parse results.
// ----------------------------------------------------------------------------
interface jmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface jmhp_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     item_kind;
  logic                           is_eor;
  logic [7:0]                     data_byte;
  logic [jmhp_pkg::ID_W-1:0]      in_class_id;
  logic                           complete_bin;
  logic [jmhp_pkg::CLS_W-1:0]     class_id;
  logic [jmhp_pkg::VAL_W-1:0]     codestream_id;
  logic [jmhp_pkg::VAL_W-1:0]     msg_offset;
  logic [jmhp_pkg::VAL_W-1:0]     msg_length;
  logic [jmhp_pkg::VAL_W-1:0]     aux_value;
  logic [jmhp_pkg::HLEN_W-1:0]    header_length;
  logic                           last_of_message;

  modport source (output valid, output item_kind, output is_eor, output data_byte,
                  output in_class_id, output complete_bin, output class_id,
                  output codestream_id, output msg_offset, output msg_length,
                  output aux_value, output header_length, output last_of_message,
                  input ready);
  modport sink (input valid, input item_kind, input is_eor, input data_byte,
                input in_class_id, input complete_bin, input class_id,
                input codestream_id, input msg_offset, input msg_length,
                input aux_value, input header_length, input last_of_message,
                output ready);
endinterface

FILE: rtl/jpip_message_header_parser_core.sv
// ----------------------------------------------------------------------------
// JPIP message header parser core
// Parses a JPIP response byte stream into header, body-byte and error results.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock while the input is not stalled. Each byte
// is parsed by a single pass of logic from the parser state into the result
// register, so a result (header, body byte or error) appears in the cycle after
// its byte is taken; header bytes that complete no field give no result. The
// input stalls only while the result register holds a transaction that the
// sink has not taken. After an error the next byte is taken as a Bin-ID byte.
module jpip_message_header_parser_core #(
  parameter int MAX_VBAS_BYTES = jmhp_pkg::MAX_VBAS_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  jmhp_in_if.sink           in_s,
  jmhp_out_if.source        out_s
);

  localparam int CntW = $clog2(MAX_VBAS_BYTES + 2);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VBAS_BYTES);

  localparam int IdW  = jmhp_pkg::ID_W;
  localparam int ClsW = jmhp_pkg::CLS_W;
  localparam int ValW = jmhp_pkg::VAL_W;
  localparam int HlW  = jmhp_pkg::HLEN_W;

  jmhp_pkg::phase_t   phase_r, phase_nxt;
  logic [1:0]         ind_r, ind_nxt;
  logic [ClsW-1:0]    rem_cls_r, rem_cls_nxt;
  logic [ValW-1:0]    rem_csn_r, rem_csn_nxt;
  logic [IdW-1:0]     acc_r, acc_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [IdW-1:0]     id_r, id_nxt;
  logic [ClsW-1:0]    cls_r, cls_nxt;
  logic [ValW-1:0]    csn_r, csn_nxt;
  logic [ValW-1:0]    off_r, off_nxt;
  logic [ValW-1:0]    len_r, len_nxt;
  logic [ValW-1:0]    aux_r, aux_nxt;
  logic [HlW-1:0]     hcnt_r, hcnt_nxt;
  logic [ValW-1:0]    brem_r, brem_nxt;
  logic               eor_r, eor_nxt;
  logic               cmp_r, cmp_nxt;
  logic [7:0]         code_r, code_nxt;

  logic               out_vld_r, out_vld_nxt;
  jmhp_pkg::res_t     res_r, res_nxt;

  logic               accept;
  logic               res_vld;
  logic               res_err;
  logic               res_last;
  jmhp_pkg::kind_t    res_kind;
  logic [7:0]         res_data;
  logic               do_binid;
  logic               do_class;
  logic               do_hdr;
  logic [IdW-1:0]     bin_id;
  logic [7:0]         b;
  logic [IdW-1:0]     acc_s;
  logic [CntW-1:0]    cnt_s;

  assign b      = in_s.in_byte;
  assign in_s.ready = !out_vld_r || out_s.ready;
  assign accept = in_s.valid && in_s.ready;
  assign acc_s  = {acc_r[IdW-8:0], b[6:0]};
  assign cnt_s  = cnt_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    ind_nxt     = ind_r;
    rem_cls_nxt = rem_cls_r;
    rem_csn_nxt = rem_csn_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    id_nxt      = id_r;
    cls_nxt     = cls_r;
    csn_nxt     = csn_r;
    off_nxt     = off_r;
    len_nxt     = len_r;
    aux_nxt     = aux_r;
    hcnt_nxt    = hcnt_r;
    brem_nxt    = brem_r;
    eor_nxt     = eor_r;
    cmp_nxt     = cmp_r;
    code_nxt    = code_r;
    res_vld     = 1'b0;
    res_err     = 1'b0;
    res_last    = 1'b0;
    res_kind    = jmhp_pkg::KIND_HEADER;
    res_data    = '0;
    do_binid    = 1'b0;
    do_class    = 1'b0;
    do_hdr      = 1'b0;
    bin_id      = acc_s;

    if (phase_r == jmhp_pkg::PH_BODY) begin
      brem_nxt = brem_r - 1'b1;
      res_vld  = 1'b1;
      res_kind = jmhp_pkg::KIND_BODY;
      res_data = b;
      res_last = (brem_nxt == '0);
      if (brem_nxt == '0) begin
        phase_nxt = jmhp_pkg::PH_BINID;
      end
    end else if (phase_r == jmhp_pkg::PH_BINID) begin
      id_nxt   = '0;
      cls_nxt  = '0;
      csn_nxt  = '0;
      off_nxt  = '0;
      len_nxt  = '0;
      aux_nxt  = '0;
      eor_nxt  = 1'b0;
      cmp_nxt  = 1'b0;
      code_nxt = '0;
      ind_nxt  = '0;
      hcnt_nxt = HlW'(1);
      if (b == 8'h00) begin
        eor_nxt   = 1'b1;
        phase_nxt = jmhp_pkg::PH_EORCODE;
      end else if (b[6:5] == 2'b00) begin
        res_vld  = 1'b1;
        res_err  = 1'b1;
        res_kind = jmhp_pkg::KIND_BAD_IND;
        acc_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        ind_nxt = b[6:5];
        cmp_nxt = b[4];
        acc_nxt = IdW'(b[3:0]);
        cnt_nxt = CntW'(1);
        if (b[7]) begin
          phase_nxt = jmhp_pkg::PH_BINEXT;
        end else begin
          do_binid = 1'b1;
          bin_id   = IdW'(b[3:0]);
        end
      end
    end else begin
      if (hcnt_r != jmhp_pkg::HDR_LEN_MAX) begin
        hcnt_nxt = hcnt_r + 1'b1;
      end
      if (phase_r == jmhp_pkg::PH_EORCODE) begin
        eor_nxt   = 1'b1;
        cmp_nxt   = 1'b0;
        code_nxt  = b;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = jmhp_pkg::PH_EORLEN;
      end else begin
        acc_nxt = acc_s;
        cnt_nxt = cnt_s;
        if (cnt_s > CntMax) begin
          res_vld   = 1'b1;
          res_err   = 1'b1;
          res_kind  = jmhp_pkg::KIND_VBAS_LONG;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = jmhp_pkg::PH_BINID;
        end else if (!b[7]) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (phase_r == jmhp_pkg::PH_BINEXT) begin
            do_binid = 1'b1;
          end else if (phase_r == jmhp_pkg::PH_CLASS) begin
            if (acc_s > jmhp_pkg::CLASS_MAX) begin
              res_vld   = 1'b1;
              res_err   = 1'b1;
              res_kind  = jmhp_pkg::KIND_BAD_CLASS;
              phase_nxt = jmhp_pkg::PH_BINID;
            end else begin
              cls_nxt     = acc_s[ClsW-1:0];
              rem_cls_nxt = acc_s[ClsW-1:0];
              do_class    = 1'b1;
            end
          end else if (|acc_s[IdW-1:ValW]) begin
            res_vld   = 1'b1;
            res_err   = 1'b1;
            res_kind  = jmhp_pkg::KIND_RANGE;
            phase_nxt = jmhp_pkg::PH_BINID;
          end else begin
            unique case (phase_r)
              jmhp_pkg::PH_CSN: begin
                csn_nxt     = acc_s[ValW-1:0];
                rem_csn_nxt = acc_s[ValW-1:0];
                phase_nxt   = jmhp_pkg::PH_OFFSET;
              end
              jmhp_pkg::PH_OFFSET: begin
                off_nxt   = acc_s[ValW-1:0];
                phase_nxt = jmhp_pkg::PH_LENGTH;
              end
              jmhp_pkg::PH_LENGTH: begin
                len_nxt = acc_s[ValW-1:0];
                if (cls_r[0]) begin
                  phase_nxt = jmhp_pkg::PH_AUX;
                end else begin
                  do_hdr = 1'b1;
                end
              end
              jmhp_pkg::PH_AUX: begin
                aux_nxt = acc_s[ValW-1:0];
                do_hdr  = 1'b1;
              end
              default: begin
                len_nxt = acc_s[ValW-1:0];
                do_hdr  = 1'b1;
              end
            endcase
          end
        end
      end
    end

    if (do_binid) begin
      id_nxt  = bin_id;
      acc_nxt = '0;
      cnt_nxt = '0;
      if (ind_nxt[1]) begin
        phase_nxt = jmhp_pkg::PH_CLASS;
      end else begin
        cls_nxt  = rem_cls_r;
        do_class = 1'b1;
      end
    end

    if (do_class) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      if (ind_nxt == 2'd3) begin
        phase_nxt = jmhp_pkg::PH_CSN;
      end else begin
        csn_nxt   = rem_csn_r;
        phase_nxt = jmhp_pkg::PH_OFFSET;
      end
    end

    if (do_hdr) begin
      res_vld  = 1'b1;
      res_kind = jmhp_pkg::KIND_HEADER;
      res_data = code_nxt;
      res_last = (len_nxt == '0);
      if (len_nxt == '0) begin
        phase_nxt = jmhp_pkg::PH_BINID;
      end else begin
        brem_nxt  = len_nxt;
        phase_nxt = jmhp_pkg::PH_BODY;
      end
    end
  end

  always_comb begin
    res_nxt.item_kind       = res_kind;
    res_nxt.is_eor          = eor_nxt;
    res_nxt.data_byte       = res_data;
    res_nxt.in_class_id     = id_nxt;
    res_nxt.complete_bin    = cmp_nxt;
    res_nxt.class_id        = cls_nxt;
    res_nxt.codestream_id   = csn_nxt;
    res_nxt.msg_offset      = off_nxt;
    res_nxt.msg_length      = len_nxt;
    res_nxt.aux_value       = aux_nxt;
    res_nxt.header_length   = hcnt_nxt;
    res_nxt.last_of_message = res_last;
    if (res_err) begin
      res_nxt                 = '0;
      res_nxt.item_kind       = res_kind;
      res_nxt.last_of_message = 1'b1;
    end
  end

  always_comb begin
    if (accept) begin
      out_vld_nxt = res_vld;
    end else if (out_s.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= jmhp_pkg::PH_BINID;
      ind_r     <= '0;
      rem_cls_r <= '0;
      rem_csn_r <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      id_r      <= '0;
      cls_r     <= '0;
      csn_r     <= '0;
      off_r     <= '0;
      len_r     <= '0;
      aux_r     <= '0;
      hcnt_r    <= '0;
      brem_r    <= '0;
      eor_r     <= 1'b0;
      cmp_r     <= 1'b0;
      code_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (accept) begin
        phase_r   <= phase_nxt;
        ind_r     <= ind_nxt;
        rem_cls_r <= rem_cls_nxt;
        rem_csn_r <= rem_csn_nxt;
        acc_r     <= acc_nxt;
        cnt_r     <= cnt_nxt;
        id_r      <= id_nxt;
        cls_r     <= cls_nxt;
        csn_r     <= csn_nxt;
        off_r     <= off_nxt;
        len_r     <= len_nxt;
        aux_r     <= aux_nxt;
        hcnt_r    <= hcnt_nxt;
        brem_r    <= brem_nxt;
        eor_r     <= eor_nxt;
        cmp_r     <= cmp_nxt;
        code_r    <= code_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_s.valid           = out_vld_r;
  assign out_s.item_kind       = res_r.item_kind;
  assign out_s.is_eor          = res_r.is_eor;
  assign out_s.data_byte       = res_r.data_byte;
  assign out_s.in_class_id     = res_r.in_class_id;
  assign out_s.complete_bin    = res_r.complete_bin;
  assign out_s.class_id        = res_r.class_id;
  assign out_s.codestream_id   = res_r.codestream_id;
  assign out_s.msg_offset      = res_r.msg_offset;
  assign out_s.msg_length      = res_r.msg_length;
  assign out_s.aux_value       = res_r.aux_value;
  assign out_s.header_length   = res_r.header_length;
  assign out_s.last_of_message = res_r.last_of_message;

endmodule

FILE: rtl/jmhp_checker.sv
// ----------------------------------------------------------------------------
// JPIP message header parser checker
// Port-level assertions on the parser result stream, bound to the core.
// ----------------------------------------------------------------------------
module jmhp_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    item_kind,
  input logic                          is_eor,
  input logic [jmhp_pkg::ID_W-1:0]     in_class_id,
  input logic [jmhp_pkg::CLS_W-1:0]    class_id,
  input logic [jmhp_pkg::VAL_W-1:0]    msg_length,
  input logic [jmhp_pkg::HLEN_W-1:0]   header_length,
  input logic                          last_of_message
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(msg_length))
    else $error("result transaction changed while stalled");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind >= 3'(jmhp_pkg::KIND_BAD_IND))
    |-> last_of_message && (header_length == '0) && !is_eor)
    else $error("error result not cleared or not last");

  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == 3'(jmhp_pkg::KIND_HEADER))
    |-> (last_of_message == (msg_length == '0)) && (header_length != '0))
    else $error("header last flag does not match body length");

  a_eor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_eor |-> (in_class_id == '0) && (class_id == '0))
    else $error("end-of-response result carries bin fields");

endmodule

bind jpip_message_header_parser_core jmhp_port_checker u_jmhp_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_s.ready),
  .out_valid       (out_s.valid),
  .out_ready       (out_s.ready),
  .item_kind       (out_s.item_kind),
  .is_eor          (out_s.is_eor),
  .in_class_id     (out_s.in_class_id),
  .class_id        (out_s.class_id),
  .msg_length      (out_s.msg_length),
  .header_length   (out_s.header_length),
  .last_of_message (out_s.last_of_message)
);
